>>> rtl/gcnsn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcnsn_pkg: shared types and constants of the GCN aggregation block
// Field widths, fixed-point constants, the reciprocal-root table builder and
// the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package gcnsn_pkg;

  // Default values of the top-level parameters.
  localparam int MAX_FEATURES_DEF = 256;
  localparam int MAX_DEGREE_DEF   = 1023;
  localparam int VALUE_WIDTH_DEF  = 16;

  // Fixed field widths.
  localparam int IDX_W  = 8;
  localparam int DEG_W  = 10;
  localparam int ACC_W  = 32;

  // Reciprocal root is unsigned Q1.16.
  localparam int ROOT_W    = 17;
  localparam int ROOT_FRAC = 16;
  localparam int ROM_DEPTH = 1 << DEG_W;

  typedef logic [ROOT_W-1:0] root_t;
  typedef root_t root_rom_t [ROM_DEPTH];

  // Controller commands to the datapath.
  typedef struct packed {
    logic capture;  // latch the item, start RAM and ROM reads
    logic mul1;     // scale value by source root, fetch target root
    logic add;      // accumulate and write back
    logic mul2;     // scale accumulator by target root
    logic load;     // round, clip and load the output register
  } cmd_t;

  // Datapath status to the controller.
  typedef struct packed {
    logic in_range;  // offered index is inside the accumulator store
    logic last;      // latched item finishes its feature element
  } status_t;

  // Largest r with r*r*n <= 2^32, which is floor(2^16 / sqrt(n)).
  function automatic root_t recip_root(input logic [31:0] n);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = ROOT_W - 1; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t * {32'd0, n} <= 64'h1_0000_0000) begin
        r = t;
      end
    end
    return r[ROOT_W-1:0];
  endfunction

  // Table over every degree code, degrees above the limit clamped to it.
  function automatic root_rom_t build_root_rom(input int max_degree);
    root_rom_t rom;
    int        dd;
    for (int d = 0; d < ROM_DEPTH; d++) begin
      dd = (d > max_degree) ? max_degree : d;
      rom[d] = recip_root(32'(dd + 1));
    end
    return rom;
  endfunction

endpackage
`default_nettype wire

>>> rtl/gcnsn_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcnsn_if: channel interfaces of the GCN aggregation block
// Valid/ready channels for contributions coming in and embedding elements
// going out.
// ----------------------------------------------------------------------------

// Contribution channel.
interface gcnsn_in_if
  import gcnsn_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic [IDX_W-1:0]              feature_index;
  logic signed [VALUE_WIDTH-1:0] feature_value;
  logic [DEG_W-1:0]              source_degree;
  logic [DEG_W-1:0]              target_degree;
  logic                          first_contribution;
  logic                          last_contribution;

  modport source (
    output valid, feature_index, feature_value, source_degree, target_degree,
           first_contribution, last_contribution,
    input  ready
  );
  modport sink (
    input  valid, feature_index, feature_value, source_degree, target_degree,
           first_contribution, last_contribution,
    output ready
  );
endinterface

// Embedding element channel.
interface gcnsn_out_if
  import gcnsn_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic [IDX_W-1:0]              out_feature_index;
  logic signed [VALUE_WIDTH-1:0] embedding_value;
  logic                          saturated;

  modport source (
    output valid, out_feature_index, embedding_value, saturated,
    input  ready
  );
  modport sink (
    input  valid, out_feature_index, embedding_value, saturated,
    output ready
  );
endinterface
`default_nettype wire

>>> rtl/gcn_symmetric_norm_aggregate.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcn_symmetric_norm_aggregate: GCN aggregation with symmetric normalization
// Accumulates value/sqrt(source degree + 1) per feature element and emits the
// sum times 1/sqrt(target degree + 1) on the last contribution.
// ----------------------------------------------------------------------------
// One contribution is handled at a time. An item whose index lies beyond the
// accumulator store is taken and dropped. Any other item passes through
// capture with the accumulator RAM read and the root ROM read, the multiply
// by the source root, then the rounded add with write-back into the RAM. A
// last contribution adds the multiply by the target root and the output
// rounding into the output register; that stage waits only while the output
// register still holds an untaken result. The accumulator read-modify-write
// through the one RAM and the two dependent multiplies sharing one ROM port
// set this sequence.
// Accumulators come up undefined after reset: each feature element must start
// with a contribution that has first_contribution set.
module gcn_symmetric_norm_aggregate
  import gcnsn_pkg::*;
#(
  parameter int MAX_FEATURES = MAX_FEATURES_DEF,
  parameter int MAX_DEGREE   = MAX_DEGREE_DEF,
  parameter int VALUE_WIDTH  = VALUE_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  gcnsn_in_if.sink     in_ch,
  gcnsn_out_if.source  out_ch
);

  cmd_t    cmd;
  status_t status;

  // Sequencer.
  gcnsn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath.
  gcnsn_dp #(
    .MAX_FEATURES (MAX_FEATURES),
    .MAX_DEGREE   (MAX_DEGREE),
    .VALUE_WIDTH  (VALUE_WIDTH)
  ) u_dp (
    .clk                (clk),
    .cmd                (cmd),
    .status             (status),
    .feature_index      (in_ch.feature_index),
    .feature_value      (in_ch.feature_value),
    .source_degree      (in_ch.source_degree),
    .target_degree      (in_ch.target_degree),
    .first_contribution (in_ch.first_contribution),
    .last_contribution  (in_ch.last_contribution),
    .out_feature_index  (out_ch.out_feature_index),
    .embedding_value    (out_ch.embedding_value),
    .saturated          (out_ch.saturated)
  );

endmodule
`default_nettype wire

>>> rtl/gcnsn_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcnsn_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gcnsn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

>>> rtl/gcnsn_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcnsn_ctrl: sequencer of the GCN aggregation block
// Steps one contribution through read, scale, accumulate and, on the last
// contribution, the output scaling; owns both handshakes.
// ----------------------------------------------------------------------------
module gcnsn_ctrl
  import gcnsn_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL1 = 3'd1;
  localparam logic [2:0] ST_ADD  = 3'd2;
  localparam logic [2:0] ST_MUL2 = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       accept;
  logic       out_free;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  // The output register can take a value when empty or being drained.
  assign out_free = !out_valid_r || out_ready;

  // Next state and commands.
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.capture = accept;
    case (state_r)
      ST_IDLE: begin
        if (accept && status.in_range) begin
          state_nxt = ST_MUL1;
        end
      end
      ST_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = status.last ? ST_MUL2 : ST_IDLE;
      end
      ST_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          cmd.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

>>> rtl/gcnsn_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcnsn_dp: datapath of the GCN aggregation block
// Item registers, reciprocal-root ROM, accumulator RAM, the two scaling
// multipliers with rounding and saturation, and the output register.
// ----------------------------------------------------------------------------
module gcnsn_dp
  import gcnsn_pkg::*;
#(
  parameter int MAX_FEATURES = MAX_FEATURES_DEF,
  parameter int MAX_DEGREE   = MAX_DEGREE_DEF,
  parameter int VALUE_WIDTH  = VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  cmd_t                          cmd,
  output status_t                       status,
  input  logic [IDX_W-1:0]              feature_index,
  input  logic signed [VALUE_WIDTH-1:0] feature_value,
  input  logic [DEG_W-1:0]              source_degree,
  input  logic [DEG_W-1:0]              target_degree,
  input  logic                          first_contribution,
  input  logic                          last_contribution,
  output logic [IDX_W-1:0]              out_feature_index,
  output logic signed [VALUE_WIDTH-1:0] embedding_value,
  output logic                          saturated
);

  localparam int AW   = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  // Value times root, and its rounded quotient.
  localparam int PW1  = VALUE_WIDTH + ROOT_W + 1;
  localparam int SW1  = PW1 - ROOT_FRAC;
  localparam int SUMW = ((SW1 > ACC_W) ? SW1 : ACC_W) + 1;
  // Accumulator times root, and its rounded quotient.
  localparam int PW2  = ACC_W + ROOT_W + 1;
  localparam int RW2  = PW2 - ROOT_FRAC;

  localparam root_rom_t ROOT_ROM = build_root_rom(MAX_DEGREE);

  localparam logic signed [PW1-1:0] HALF1 =
    {{(PW1-ROOT_FRAC){1'b0}}, 1'b1, {(ROOT_FRAC-1){1'b0}}};
  localparam logic signed [PW2-1:0] HALF2 =
    {{(PW2-ROOT_FRAC){1'b0}}, 1'b1, {(ROOT_FRAC-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  // Item registers.
  logic [IDX_W-1:0]              idx_r;
  logic signed [VALUE_WIDTH-1:0] val_r;
  logic [DEG_W-1:0]              tdeg_r;
  logic                          first_r;
  logic                          last_r;

  // Arithmetic registers.
  root_t                         root_r;
  logic signed [PW1-1:0]         prod1_r;
  logic signed [ACC_W-1:0]       acc_r;
  logic signed [PW2-1:0]         prod2_r;

  // Output register.
  logic [IDX_W-1:0]              out_idx_r;
  logic signed [VALUE_WIDTH-1:0] emb_r;
  logic                          sat_r;

  logic [DEG_W-1:0]              rom_addr;
  logic [ACC_W-1:0]              rd_data;
  logic signed [PW1-1:0]         prod1_nxt;
  logic signed [PW1-1:0]         rnd1;
  logic signed [SW1-1:0]         scaled;
  logic signed [ACC_W-1:0]       acc_base;
  logic signed [SUMW-1:0]        sum;
  logic [SUMW-ACC_W:0]           sum_top;
  logic signed [ACC_W-1:0]       acc_nxt;
  logic signed [PW2-1:0]         prod2_nxt;
  logic signed [PW2-1:0]         rnd2;
  logic signed [RW2-1:0]         res;
  logic [RW2-VALUE_WIDTH:0]      res_top;
  logic signed [VALUE_WIDTH-1:0] emb_nxt;
  logic                          sat_nxt;

  // Items with an index past the store are dropped.
  assign status.in_range = ({{(32-IDX_W){1'b0}}, feature_index} < 32'(MAX_FEATURES));
  assign status.last     = last_r;

  // Latch the item.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      idx_r   <= feature_index;
      val_r   <= feature_value;
      tdeg_r  <= target_degree;
      first_r <= first_contribution;
      last_r  <= last_contribution;
    end
  end

  // Root ROM: source degree at capture, target degree during the first multiply.
  assign rom_addr = cmd.capture ? source_degree : tdeg_r;

  always_ff @(posedge clk) begin
    if (cmd.capture || cmd.mul1) begin
      root_r <= ROOT_ROM[rom_addr];
    end
  end

  // Accumulator store, read at capture and written back after the add.
  gcnsn_ram #(
    .WIDTH (ACC_W),
    .DEPTH (MAX_FEATURES)
  ) u_acc_ram (
    .clk   (clk),
    .we    (cmd.add),
    .waddr (AW'(idx_r)),
    .wdata (acc_nxt),
    .re    (cmd.capture),
    .raddr (AW'(feature_index)),
    .rdata (rd_data)
  );

  // Value times source root.
  assign prod1_nxt = PW1'(val_r) * PW1'($signed({1'b0, root_r}));

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      prod1_r <= prod1_nxt;
    end
  end

  // Round half up, add into the accumulator and clip to 32 bits.
  assign rnd1     = prod1_r + HALF1;
  assign scaled   = $signed(rnd1[PW1-1:ROOT_FRAC]);
  assign acc_base = first_r ? '0 : $signed(rd_data);
  assign sum      = SUMW'(acc_base) + SUMW'(scaled);
  assign sum_top  = sum[SUMW-1:ACC_W-1];

  always_comb begin
    if ((&sum_top) || !(|sum_top)) begin
      acc_nxt = sum[ACC_W-1:0];
    end else if (sum[SUMW-1]) begin
      acc_nxt = ACC_MIN;
    end else begin
      acc_nxt = ACC_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add) begin
      acc_r <= acc_nxt;
    end
  end

  // Accumulator times target root.
  assign prod2_nxt = PW2'(acc_r) * PW2'($signed({1'b0, root_r}));

  always_ff @(posedge clk) begin
    if (cmd.mul2) begin
      prod2_r <= prod2_nxt;
    end
  end

  // Round half up and clip to the value width.
  assign rnd2    = prod2_r + HALF2;
  assign res     = $signed(rnd2[PW2-1:ROOT_FRAC]);
  assign res_top = res[RW2-1:VALUE_WIDTH-1];

  always_comb begin
    if ((&res_top) || !(|res_top)) begin
      emb_nxt = res[VALUE_WIDTH-1:0];
      sat_nxt = 1'b0;
    end else if (res[RW2-1]) begin
      emb_nxt = VAL_MIN;
      sat_nxt = 1'b1;
    end else begin
      emb_nxt = VAL_MAX;
      sat_nxt = 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_idx_r <= idx_r;
      emb_r     <= emb_nxt;
      sat_r     <= sat_nxt;
    end
  end

  assign out_feature_index = out_idx_r;
  assign embedding_value   = emb_r;
  assign saturated         = sat_r;

endmodule
`default_nettype wire

>>> rtl/gcnsn_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcnsn_checker: port-level checks of the GCN aggregation block
// Watches the two channels and is bound to the top level.
// ----------------------------------------------------------------------------
module gcnsn_checker
  import gcnsn_pkg::*;
#(
  parameter int MAX_FEATURES = MAX_FEATURES_DEF,
  parameter int VALUE_WIDTH  = VALUE_WIDTH_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [IDX_W-1:0]              in_index,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [IDX_W-1:0]              out_index,
  input logic signed [VALUE_WIDTH-1:0] out_value,
  input logic                          out_sat
);

  localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  logic in_take;
  logic in_kept;

  assign in_take = in_valid && in_ready;
  assign in_kept = in_take && ({{(32-IDX_W){1'b0}}, in_index} < 32'(MAX_FEATURES));

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // A kept request occupies the block for the following cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n) in_kept |=> !in_ready)
    else $error("request taken while the previous one is in progress");

  // No result can appear right after a request is taken.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> !$rose(out_valid))
    else $error("result appeared too early");

  // A clipped result sits at one end of the range.
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_sat) |-> (out_value == VAL_MAX || out_value == VAL_MIN))
    else $error("saturated flag without a clipped value");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_index) && $stable(out_value) && $stable(out_sat)))
    else $error("stalled result changed");

endmodule

bind gcn_symmetric_norm_aggregate gcnsn_checker #(
  .MAX_FEATURES (MAX_FEATURES),
  .VALUE_WIDTH  (VALUE_WIDTH)
) u_gcnsn_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_index  (in_ch.feature_index),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_index (out_ch.out_feature_index),
  .out_value (out_ch.embedding_value),
  .out_sat   (out_ch.saturated)
);
`default_nettype wire

>>> tb/gcn_symmetric_norm_aggregate_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcn_symmetric_norm_aggregate_tb: self-checking bench of the GCN aggregation
// Streams contributions through the input channel with random gaps and
// back-pressure. A scoreboard predicts each embedding element from its own
// copy of the accumulators and compares every result field by field.
// ----------------------------------------------------------------------------
module gcn_symmetric_norm_aggregate_tb;
  import gcnsn_pkg::*;

  localparam int VW          = VALUE_WIDTH_DEF;
  localparam int STALL_LIMIT = 1000;
  localparam int SETTLE      = 20;

  typedef struct {
    logic [IDX_W-1:0]     index;
    logic signed [VW-1:0] value;
    logic                 sat;
  } embedding_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  gcnsn_in_if  contrib ();
  gcnsn_out_if embed ();

  gcn_symmetric_norm_aggregate dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (contrib),
    .out_ch (embed)
  );

  always #5 clk = ~clk;

  // Scoreboard state: accumulator copy, root table and pending embeddings.
  int         acc_store [MAX_FEATURES_DEF];
  longint     root_table [1 << DEG_W];
  embedding_t pending_embeddings [$];
  bit         cleared [MAX_FEATURES_DEF];

  int gap_max     = 11;
  int sink_max    = 11;
  int sink_stall  = 0;
  int error_count = 0;
  int quiet_count = 0;

  // Q1.16 reciprocal square root of degree + 1, found by integer search.
  function automatic longint inv_sqrt_q16(int degree);
    longint quotient;
    longint lo;
    longint hi;
    longint mid;
    int     n;
    n = ((degree > MAX_DEGREE_DEF) ? MAX_DEGREE_DEF : degree) + 1;
    quotient = (longint'(1) << 32) / n;
    lo = 0;
    hi = 65537;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (mid * mid <= quotient) begin
        lo = mid;
      end else begin
        hi = mid;
      end
    end
    return lo;
  endfunction

  // Drop 16 fraction bits, rounding halves toward plus infinity.
  function automatic longint round_q16(longint x);
    return (x + 32768) >>> 16;
  endfunction

  initial begin
    for (int d = 0; d < (1 << DEG_W); d++) begin
      root_table[d] = inv_sqrt_q16(d);
    end
  end

  // Apply one accepted contribution and queue the embedding it finishes.
  function automatic void accumulate_contribution(
    logic [IDX_W-1:0] idx, logic signed [VW-1:0] value,
    logic [DEG_W-1:0] src_deg, logic [DEG_W-1:0] tgt_deg,
    logic first, logic last
  );
    longint     sum;
    longint     res;
    longint     vmax;
    embedding_t e;
    if (int'(idx) >= MAX_FEATURES_DEF) return;
    vmax = (longint'(1) << (VW - 1)) - 1;
    sum = first ? 0 : longint'(acc_store[idx]);
    sum += round_q16(longint'(value) * root_table[src_deg]);
    if (sum > 64'sd2147483647) sum = 64'sd2147483647;
    if (sum < -64'sd2147483648) sum = -64'sd2147483648;
    acc_store[idx] = int'(sum);
    if (!last) return;
    res = round_q16(sum * root_table[tgt_deg]);
    e.sat = 1'b0;
    if (res > vmax) begin
      res   = vmax;
      e.sat = 1'b1;
    end
    if (res < -vmax - 1) begin
      res   = -vmax - 1;
      e.sat = 1'b1;
    end
    e.index = idx;
    e.value = res[VW-1:0];
    pending_embeddings.push_back(e);
  endfunction

  // Predict on each accepted request, then check each accepted result.
  always @(posedge clk) begin
    embedding_t want;
    if (rst_n && contrib.valid === 1'b1 && contrib.ready === 1'b1) begin
      accumulate_contribution(contrib.feature_index, contrib.feature_value,
                              contrib.source_degree, contrib.target_degree,
                              contrib.first_contribution, contrib.last_contribution);
    end
    if (rst_n && embed.valid === 1'b1 && embed.ready === 1'b1) begin
      if (pending_embeddings.size() == 0) begin
        error_count++;
        $error("unexpected result: out_feature_index %0d embedding_value %0d",
               embed.out_feature_index, embed.embedding_value);
      end else begin
        want = pending_embeddings.pop_front();
        if (embed.out_feature_index !== want.index) begin
          error_count++;
          $error("out_feature_index: expected %0d, actual %0d",
                 want.index, embed.out_feature_index);
        end
        if (embed.embedding_value !== want.value) begin
          error_count++;
          $error("embedding_value: expected %0d, actual %0d",
                 want.value, embed.embedding_value);
        end
        if (embed.saturated !== want.sat) begin
          error_count++;
          $error("saturated: expected %0d, actual %0d", want.sat, embed.saturated);
        end
      end
    end
  end

  // Result side back-pressure: a random stall after each taken result.
  always @(posedge clk) begin
    if (!rst_n) begin
      sink_stall = 0;
      embed.ready <= 1'b1;
    end else if (embed.ready === 1'b1) begin
      if (embed.valid === 1'b1) begin
        sink_stall = $urandom_range(0, sink_max);
        if (sink_stall > 0) embed.ready <= 1'b0;
      end
    end else if (sink_stall <= 1) begin
      sink_stall = 0;
      embed.ready <= 1'b1;
    end else begin
      sink_stall--;
    end
  end

  // Watchdog on cycles in which neither channel moves a request.
  always @(posedge clk) begin
    if ((contrib.valid === 1'b1 && contrib.ready === 1'b1) ||
        (embed.valid === 1'b1 && embed.ready === 1'b1)) begin
      quiet_count = 0;
    end else begin
      quiet_count++;
      if (quiet_count >= STALL_LIMIT) begin
        $display("gcn_symmetric_norm_aggregate_tb: errors");
        $finish;
      end
    end
  end

  // Send one contribution after a random gap and wait until it is taken.
  task automatic send_contribution(
    input logic [IDX_W-1:0] idx, input logic signed [VW-1:0] value,
    input logic [DEG_W-1:0] src_deg, input logic [DEG_W-1:0] tgt_deg,
    input logic first, input logic last
  );
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      contrib.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (first) cleared[idx] = 1'b1;
    contrib.feature_index      <= idx;
    contrib.feature_value      <= value;
    contrib.source_degree      <= src_deg;
    contrib.target_degree      <= tgt_deg;
    contrib.first_contribution <= first;
    contrib.last_contribution  <= last;
    contrib.valid              <= 1'b1;
    do @(posedge clk); while (contrib.ready !== 1'b1);
  endtask

  // Hold off the sender until every pending embedding has come out.
  task automatic wait_for_drain();
    contrib.valid <= 1'b0;
    @(posedge clk);
    while (pending_embeddings.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [VW-1:0] pick_value();
    int r;
    r = $urandom_range(0, 7);
    case (r)
      0: pick_value = {1'b1, {(VW - 1){1'b0}}};
      1: pick_value = {1'b0, {(VW - 1){1'b1}}};
      2: pick_value = '1;
      3, 4: pick_value = VW'(int'($urandom_range(0, 1023)) - 512);
      default: pick_value = VW'($urandom);
    endcase
  endfunction

  function automatic logic [DEG_W-1:0] pick_degree();
    int r;
    r = $urandom_range(0, 5);
    case (r)
      0: pick_degree = $urandom_range(0, 1) ? '1 : '0;
      1, 2: pick_degree = DEG_W'($urandom_range(0, 7));
      default: pick_degree = DEG_W'($urandom);
    endcase
  endfunction

  // Index, value and degree extremes, each as a single-item element.
  task automatic test_field_extremes();
    send_contribution(8'd0, 16'sh7FFF, 10'd0, 10'd0, 1'b1, 1'b1);
    send_contribution(8'd255, 16'sh8000, 10'd1023, 10'd1023, 1'b1, 1'b1);
    send_contribution(8'd128, 16'sh8000, 10'd0, 10'd0, 1'b1, 1'b1);
    send_contribution(8'd127, 16'sh7FFF, 10'd1023, 10'd0, 1'b1, 1'b1);
    send_contribution(8'h55, 16'sh5555, 10'h2AA, 10'h155, 1'b1, 1'b1);
    send_contribution(8'hAA, 16'shAAAA, 10'h155, 10'h2AA, 1'b1, 1'b1);
  endtask

  // Exact halves in both multiplies; a negative half must round to zero.
  task automatic test_half_rounding();
    send_contribution(8'd1, -16'sd1, 10'd3, 10'd3, 1'b1, 1'b1);
    send_contribution(8'd2, 16'sd1, 10'd3, 10'd0, 1'b1, 1'b1);
    send_contribution(8'd4, -16'sd256, 10'd0, 10'd0, 1'b1, 1'b0);
    send_contribution(8'd4, 16'sd255, 10'd0, 10'd3, 1'b0, 1'b1);
    send_contribution(8'd5, 16'sd1, 10'd0, 10'd3, 1'b1, 1'b1);
  endtask

  // Sums beyond the output range clip and flag; a small root does not.
  task automatic test_output_clip();
    send_contribution(8'd10, 16'sh7FFF, 10'd0, 10'd0, 1'b1, 1'b0);
    send_contribution(8'd10, 16'sh7FFF, 10'd0, 10'd0, 1'b0, 1'b0);
    send_contribution(8'd10, 16'sh7FFF, 10'd0, 10'd0, 1'b0, 1'b1);
    send_contribution(8'd11, 16'sh8000, 10'd0, 10'd0, 1'b1, 1'b0);
    send_contribution(8'd11, 16'sh8000, 10'd0, 10'd0, 1'b0, 1'b1);
    send_contribution(8'd12, 16'sh7FFF, 10'd0, 10'd1023, 1'b1, 1'b0);
    send_contribution(8'd12, 16'sh7FFF, 10'd0, 10'd1023, 1'b0, 1'b0);
    send_contribution(8'd12, 16'sh7FFF, 10'd0, 10'd1023, 1'b0, 1'b1);
  endtask

  // A first contribution must discard whatever the entry held before.
  task automatic test_element_restart();
    send_contribution(8'd10, 16'sd100, 10'd0, 10'd0, 1'b1, 1'b1);
    send_contribution(8'd12, 16'sd50, 10'd0, 10'd0, 1'b1, 1'b0);
    send_contribution(8'd12, 16'sd50, 10'd0, 10'd0, 1'b0, 1'b1);
  endtask

  // Interleaved well-formed elements with random content, plus some noise.
  task automatic test_random_stream(input int count);
    logic [IDX_W-1:0] open_set [$];
    logic [IDX_W-1:0] idx;
    logic             first;
    logic             last;
    int               r;
    int               k;
    for (int sent = 0; sent < count; sent++) begin
      if (sent % 100 == 0) begin
        gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 11;
        sink_max = ($urandom_range(0, 3) == 0) ? 0 : 11;
      end
      if (sent % 400 == 200) wait_for_drain();
      r = $urandom_range(0, 99);
      if (open_set.size() == 0 || (open_set.size() < 6 && r < 25)) begin
        idx   = IDX_W'($urandom);
        first = 1'b1;
        last  = (r < 6);
        if (!last) open_set.push_back(idx);
      end else if (r < 88) begin
        k     = $urandom_range(0, open_set.size() - 1);
        idx   = open_set[k];
        first = 1'b0;
        last  = ($urandom_range(0, 3) == 0);
        if (last) open_set.delete(k);
      end else begin
        // Noise: random flags, but never a read of an entry not yet cleared.
        idx   = IDX_W'($urandom);
        first = $urandom_range(0, 1) || !cleared[idx];
        last  = $urandom_range(0, 1);
      end
      send_contribution(idx, pick_value(), pick_degree(), pick_degree(), first, last);
    end
    gap_max  = 11;
    sink_max = 11;
  endtask

  initial begin
    contrib.valid              <= 1'b0;
    contrib.feature_index      <= '0;
    contrib.feature_value      <= '0;
    contrib.source_degree      <= '0;
    contrib.target_degree      <= '0;
    contrib.first_contribution <= 1'b0;
    contrib.last_contribution  <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_field_extremes();
    test_half_rounding();
    test_output_clip();
    test_element_restart();
    test_random_stream(1630);

    wait_for_drain();
    repeat (SETTLE) @(posedge clk);
    if (error_count == 0) begin
      $display("gcn_symmetric_norm_aggregate_tb: clean");
    end else begin
      $display("gcn_symmetric_norm_aggregate_tb: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> gcn_symmetric_norm_aggregate.f
rtl/gcnsn_pkg.sv
rtl/gcnsn_if.sv
rtl/gcnsn_ram.sv
rtl/gcnsn_ctrl.sv
rtl/gcnsn_dp.sv
rtl/gcn_symmetric_norm_aggregate.sv
rtl/gcnsn_checker.sv
tb/gcn_symmetric_norm_aggregate_tb.sv
